>>> rtl/bpc_pkg.sv
// Shared types and constants for the barometric pressure compensation block.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package bpc_pkg;

  localparam int IdxW      = 3;
  localparam int CalW      = 48;
  localparam int XOffset   = 128000;
  localparam int PBase     = 1048576;
  localparam int PScale    = 3125;
  localparam int P4Shift   = 35;
  localparam int BiasShift = 47;
  localparam int DivSteps  = 64;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DISABLED = 2'd1,
    ST_INVALID  = 2'd2
  } status_e;

  typedef enum logic [IdxW-1:0] {
    REG_ENABLED   = 3'd0,
    REG_TEMP_CAL  = 3'd1,
    REG_PRESS_A   = 3'd2,
    REG_PRESS_B   = 3'd3,
    REG_PRESS_C   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic            enabled;
    logic [CalW-1:0] tcal;
    logic [CalW-1:0] pcal_a;
    logic [CalW-1:0] pcal_b;
    logic [CalW-1:0] pcal_c;
  } cfg_t;

endpackage

>>> rtl/bpc_temp.sv
// Fine-temperature pipeline, four stages, 32-bit wrapping arithmetic.
// Depends on bpc_pkg.
`timescale 1ns / 1ps

module bpc_temp import bpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  cfg_t               cfg_i,
  input  logic               vld_i,
  input  logic [19:0]        adc_p_i,
  input  logic [19:0]        adc_t_i,
  output logic               vld_o,
  output logic [19:0]        adc_p_o,
  output logic signed [31:0] tf_o
);

  logic [15:0]        t1;
  logic signed [15:0] t2, t3;
  assign t1 = cfg_i.tcal[15:0];
  assign t2 = $signed(cfg_i.tcal[31:16]);
  assign t3 = $signed(cfg_i.tcal[47:32]);

  logic [3:0]  vld_q;
  logic [19:0] adcp_q [4];

  logic signed [17:0] a_d, a_q;
  logic signed [16:0] b_d, b_q;
  logic signed [33:0] ma_d, mb_d;
  logic [31:0]        ma_q, mb_q;
  logic signed [19:0] v2a;
  logic signed [35:0] mc_d;
  logic [31:0]        mc_q;
  logic signed [20:0] v1_q;
  logic [31:0]        tf_d, tf_q;

  assign a_d  = $signed({1'b0, adc_t_i[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign b_d  = $signed({1'b0, adc_t_i[19:4]}) - $signed({1'b0, t1});
  assign ma_d = a_q * t2;
  assign mb_d = b_q * b_q;
  assign v2a  = $signed(mb_q[31:12]);
  assign mc_d = v2a * t3;
  assign tf_d = {{11{v1_q[20]}}, v1_q} + {{14{mc_q[31]}}, mc_q[31:14]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      adcp_q[0] <= adc_p_i;
      adcp_q[1] <= adcp_q[0];
      adcp_q[2] <= adcp_q[1];
      adcp_q[3] <= adcp_q[2];
      a_q       <= a_d;
      b_q       <= b_d;
      ma_q      <= ma_d[31:0];
      mb_q      <= mb_d[31:0];
      v1_q      <= $signed(ma_q[31:11]);
      mc_q      <= mc_d[31:0];
      tf_q      <= tf_d;
    end
  end

  assign vld_o   = vld_q[3];
  assign adc_p_o = adcp_q[3];
  assign tf_o    = $signed(tf_q);

endmodule

>>> rtl/bpc_poly.sv
// Pressure polynomial pipeline, six stages: dividend and divisor, 64-bit wrapping.
// Depends on bpc_pkg.
`timescale 1ns / 1ps

module bpc_poly import bpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  cfg_t               cfg_i,
  input  logic               vld_i,
  input  logic [19:0]        adc_p_i,
  input  logic signed [31:0] tf_i,
  output logic               vld_o,
  output logic signed [63:0] num_o,
  output logic signed [30:0] den_o,
  output logic signed [31:0] tf_o
);

  logic [15:0]        p1;
  logic signed [15:0] p2, p3, p4, p5, p6;
  assign p1 = cfg_i.pcal_a[15:0];
  assign p2 = $signed(cfg_i.pcal_a[31:16]);
  assign p3 = $signed(cfg_i.pcal_a[47:32]);
  assign p4 = $signed(cfg_i.pcal_b[15:0]);
  assign p5 = $signed(cfg_i.pcal_b[31:16]);
  assign p6 = $signed(cfg_i.pcal_b[47:32]);

  logic [5:0]         vld_q;
  logic signed [31:0] tf_q [6];
  logic [20:0]        pn_q [4];

  logic signed [32:0] x_q;
  logic signed [65:0] xx_d;
  logic signed [63:0] xx_q;
  logic signed [48:0] xp5_d, xp5_q, xp2_d, xp2_q;
  logic signed [79:0] y6_d, d3_d;
  logic signed [63:0] y6_q, d3_q, y5_q, d2_q;
  logic signed [63:0] y_d, y_q, dsum_d, dsum_q;
  logic signed [80:0] dp_d;
  logic signed [63:0] dp_q;
  logic [63:0]        num0_d, num0_q;
  logic signed [76:0] num_d;
  logic signed [63:0] num_q;
  logic signed [30:0] den_q;

  assign xx_d   = x_q * x_q;
  assign xp5_d  = x_q * p5;
  assign xp2_d  = x_q * p2;
  assign y6_d   = xx_q * p6;
  assign d3_d   = xx_q * p3;
  assign y_d    = y6_q + y5_q + (64'(p4) <<< P4Shift);
  assign dsum_d = (d3_q >>> 8) + d2_q + (64'sd1 <<< BiasShift);
  assign dp_d   = dsum_q * $signed({1'b0, p1});
  assign num0_d = (64'(pn_q[3]) << 31) - y_q;
  assign num_d  = $signed(num0_q) * $signed(13'(PScale));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tf_q[0] <= tf_i;
      for (int k = 1; k < 6; k++) tf_q[k] <= tf_q[k-1];
      pn_q[0] <= 21'(PBase) - {1'b0, adc_p_i};
      for (int k = 1; k < 4; k++) pn_q[k] <= pn_q[k-1];
      x_q    <= $signed({tf_i[31], tf_i}) - $signed(33'(XOffset));
      xx_q   <= xx_d[63:0];
      xp5_q  <= xp5_d;
      xp2_q  <= xp2_d;
      y6_q   <= y6_d[63:0];
      d3_q   <= d3_d[63:0];
      y5_q   <= 64'(xp5_q) <<< 17;
      d2_q   <= 64'(xp2_q) <<< 12;
      y_q    <= y_d;
      dsum_q <= dsum_d;
      dp_q   <= dp_d[63:0];
      num0_q <= num0_d;
      num_q  <= num_d[63:0];
      den_q  <= dp_q[63:33];
    end
  end

  assign vld_o = vld_q[5];
  assign num_o = num_q;
  assign den_o = den_q;
  assign tf_o  = tf_q[5];

endmodule

>>> rtl/bpc_div.sv
// Pipelined signed divider: sign stage, one quotient bit per stage, negate stage.
// Truncates toward zero. Depends on bpc_pkg.
`timescale 1ns / 1ps

module bpc_div import bpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic signed [63:0] num_i,
  input  logic signed [30:0] den_i,
  input  logic signed [31:0] tf_i,
  output logic               vld_o,
  output logic signed [63:0] quo_o,
  output logic               zero_o,
  output logic signed [31:0] tf_o
);

  typedef struct packed {
    logic [30:0] rem;
    logic [63:0] nq;
    logic [30:0] ud;
    logic        neg;
    logic        zero;
    logic [31:0] tf;
  } div_st_t;

  logic [DivSteps+1:0] vld_q;
  div_st_t             st_q [DivSteps+1];
  div_st_t             st0_d;
  logic [63:0]         quo_q;
  logic                zero_q;
  logic [31:0]         tf_q;

  function automatic div_st_t div_step(div_st_t s);
    logic [31:0] trial;
    logic        ge;
    div_st_t     nx;
    trial  = {s.rem, s.nq[63]};
    ge     = (trial >= {1'b0, s.ud});
    nx     = s;
    nx.rem = ge ? 31'(trial - {1'b0, s.ud}) : trial[30:0];
    nx.nq  = {s.nq[62:0], ge};
    return nx;
  endfunction

  always_comb begin
    st0_d.rem  = '0;
    st0_d.nq   = num_i[63] ? 64'(0 - num_i) : num_i;
    st0_d.ud   = den_i[30] ? 31'(0 - den_i) : den_i;
    st0_d.neg  = num_i[63] ^ den_i[30];
    st0_d.zero = (den_i == '0);
    st0_d.tf   = tf_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DivSteps:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= st0_d;
      for (int k = 0; k < DivSteps; k++) st_q[k+1] <= div_step(st_q[k]);
      quo_q   <= st_q[DivSteps].neg ? 64'(0 - st_q[DivSteps].nq) : st_q[DivSteps].nq;
      zero_q  <= st_q[DivSteps].zero;
      tf_q    <= st_q[DivSteps].tf;
    end
  end

  assign vld_o  = vld_q[DivSteps+1];
  assign quo_o  = $signed(quo_q);
  assign zero_o = zero_q;
  assign tf_o   = $signed(tf_q);

endmodule

>>> rtl/bpc_post.sv
// Post-division correction (P7..P9), saturation and status, six stages.
// Depends on bpc_pkg.
`timescale 1ns / 1ps

module bpc_post import bpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  cfg_t               cfg_i,
  input  logic               vld_i,
  input  logic signed [63:0] quo_i,
  input  logic               zero_i,
  input  logic signed [31:0] tf_i,
  output logic               vld_o,
  output status_e            status_o,
  output logic [31:0]        press_o,
  output logic signed [31:0] tf_o
);

  logic signed [15:0] p7, p8, p9;
  assign p7 = $signed(cfg_i.pcal_c[15:0]);
  assign p8 = $signed(cfg_i.pcal_c[31:16]);
  assign p9 = $signed(cfg_i.pcal_c[47:32]);

  logic [5:0]         vld_q;
  logic signed [63:0] q_q  [3];
  logic               zr_q [5];
  logic signed [31:0] tf_q [5];

  logic signed [50:0] ph_q;
  logic signed [66:0] a9_d;
  logic [63:0]        a9_q;
  logic signed [79:0] v2_d;
  logic signed [63:0] v2_q [3];
  logic [63:0]        ph64;
  logic [63:0]        ll_d, ll_q;
  logic [31:0]        hl_d, hl_q, lh_d, lh_q;
  logic signed [63:0] v1f_q, s_d, s_q, pf_d, pf_q;
  status_e            st_d, st_q;
  logic [31:0]        pr_d, pr_q;
  logic signed [31:0] tfo_d, tfo_q;

  assign a9_d = p9 * $signed(quo_i[63:13]);
  assign v2_d = p8 * quo_i;
  assign ph64 = 64'(ph_q);
  assign ll_d = a9_q[31:0] * ph64[31:0];
  assign hl_d = a9_q[63:32] * ph64[31:0];
  assign lh_d = a9_q[31:0] * ph64[63:32];
  assign s_d  = q_q[2] + (v1f_q >>> 25) + (v2_q[2] >>> 19);
  assign pf_d = (s_q >>> 8) + (64'(p7) <<< 4);

  always_comb begin
    st_d  = ST_OK;
    pr_d  = '0;
    tfo_d = tf_q[4];
    if (!cfg_i.enabled) begin
      st_d  = ST_DISABLED;
      tfo_d = '0;
    end else if (zr_q[4] || pf_q <= 0) begin
      st_d = ST_INVALID;
    end else if (pf_q[63:32] != '0) begin
      pr_d = '1;
    end else begin
      pr_d = pf_q[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q[0]  <= quo_i;
      zr_q[0] <= zero_i;
      tf_q[0] <= tf_i;
      for (int k = 1; k < 3; k++) q_q[k] <= q_q[k-1];
      for (int k = 1; k < 5; k++) begin
        zr_q[k] <= zr_q[k-1];
        tf_q[k] <= tf_q[k-1];
      end
      ph_q    <= quo_i[63:13];
      a9_q    <= a9_d[63:0];
      v2_q[0] <= v2_d[63:0];
      v2_q[1] <= v2_q[0];
      v2_q[2] <= v2_q[1];
      ll_q    <= ll_d;
      hl_q    <= hl_d;
      lh_q    <= lh_d;
      v1f_q   <= $signed(ll_q + {hl_q + lh_q, 32'b0});
      s_q     <= s_d;
      pf_q    <= pf_d;
      st_q    <= st_d;
      pr_q    <= pr_d;
      tfo_q   <= tfo_d;
    end
  end

  assign vld_o    = vld_q[5];
  assign status_o = st_q;
  assign press_o  = pr_q;
  assign tf_o     = tfo_q;

endmodule

>>> rtl/barometric_pressure_compensation.sv
// Pipeline: temperature, polynomial, divider with one quotient bit per stage, correction,
// then the output register.
// Throughput: one transfer per cycle; the pipeline holds only while its last stage
// and the output register are both full and the output is not taken.
// Reset: asynchronous, active low; clears all valid bits and all calibration registers.
// Top level; depends on bpc_pkg, bpc_temp, bpc_poly, bpc_div and bpc_post.
`timescale 1ns / 1ps

module barometric_pressure_compensation import bpc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [IdxW-1:0] cfg_idx_i,
  input  logic [CalW-1:0] cfg_wdata_i,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [39:0]     s_axis_tdata,   // raw_pressure[19:0], raw_temperature[39:20]
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [71:0]     m_axis_tdata    // status[1:0], pressure_q24_8[33:2],
                                          // temperature_fine[65:34], zero[71:66]
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_ENABLED:  cfg_q.enabled <= cfg_wdata_i[0];
        REG_TEMP_CAL: cfg_q.tcal    <= cfg_wdata_i;
        REG_PRESS_A:  cfg_q.pcal_a  <= cfg_wdata_i;
        REG_PRESS_B:  cfg_q.pcal_b  <= cfg_wdata_i;
        REG_PRESS_C:  cfg_q.pcal_c  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic               en, out_take;
  logic               t_vld, p_vld, d_vld, o_vld;
  logic [19:0]        t_adcp;
  logic signed [31:0] t_tf, p_tf, d_tf, o_tf;
  logic signed [63:0] p_num, d_quo;
  logic signed [30:0] p_den;
  logic               d_zero;
  status_e            o_st;
  logic [31:0]        o_pr;

  logic        out_vld_q;
  logic [65:0] out_data_q;

  assign out_take      = !out_vld_q || m_axis_tready;
  assign en            = out_take || !o_vld;
  assign s_axis_tready = en;

  bpc_temp u_temp (
    .clk_i, .rst_ni, .en_i(en), .cfg_i(cfg_q),
    .vld_i(s_axis_tvalid), .adc_p_i(s_axis_tdata[19:0]), .adc_t_i(s_axis_tdata[39:20]),
    .vld_o(t_vld), .adc_p_o(t_adcp), .tf_o(t_tf)
  );

  bpc_poly u_poly (
    .clk_i, .rst_ni, .en_i(en), .cfg_i(cfg_q),
    .vld_i(t_vld), .adc_p_i(t_adcp), .tf_i(t_tf),
    .vld_o(p_vld), .num_o(p_num), .den_o(p_den), .tf_o(p_tf)
  );

  bpc_div u_div (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(p_vld), .num_i(p_num), .den_i(p_den), .tf_i(p_tf),
    .vld_o(d_vld), .quo_o(d_quo), .zero_o(d_zero), .tf_o(d_tf)
  );

  bpc_post u_post (
    .clk_i, .rst_ni, .en_i(en), .cfg_i(cfg_q),
    .vld_i(d_vld), .quo_i(d_quo), .zero_i(d_zero), .tf_i(d_tf),
    .vld_o(o_vld), .status_o(o_st), .press_o(o_pr), .tf_o(o_tf)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_take) begin
      out_vld_q <= o_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take) begin
      out_data_q <= {o_tf, o_pr, o_st};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, out_data_q};

endmodule

>>> tb/barometric_pressure_compensation_tb.sv
// Testbench for barometric_pressure_compensation: directed and random samples through
// the stream ports, checked against an in-bench compensation predictor.
// Depends on bpc_pkg and the barometric_pressure_compensation RTL.
`timescale 1ns / 1ps

class bpc_scoreboard;
  logic [71:0] pending_q[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  function void note_sample(logic [71:0] exp_word);
    pending_q.push_back(exp_word);
  endfunction

  function void check_result(logic [71:0] got);
    logic [71:0] e;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    e = pending_q.pop_front();
    if (got[1:0] !== e[1:0]) begin
      $display("%0t: status exp %0d got %0d", $time, e[1:0], got[1:0]);
      errors++;
    end
    if (got[33:2] !== e[33:2]) begin
      $display("%0t: pressure exp %h got %h", $time, e[33:2], got[33:2]);
      errors++;
    end
    if (got[65:34] !== e[65:34]) begin
      $display("%0t: t_fine exp %h got %h", $time, e[65:34], got[65:34]);
      errors++;
    end
    if (got[71:66] !== e[71:66]) begin
      $display("%0t: pad exp %h got %h", $time, e[71:66], got[71:66]);
      errors++;
    end
  endfunction
endclass

module barometric_pressure_compensation_tb;
  import bpc_pkg::*;

  localparam int Latency = 83;

  logic            clk_i = 0;
  logic            rst_ni = 0;
  logic            cfg_we_i = 0;
  logic [IdxW-1:0] cfg_idx_i = '0;
  logic [CalW-1:0] cfg_wdata_i = '0;
  logic            s_axis_tvalid = 0;
  logic            s_axis_tready;
  logic [39:0]     s_axis_tdata = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 0;
  logic [71:0]     m_axis_tdata;

  logic            en_q;
  logic [CalW-1:0] tcal_q, pa_q, pb_q, pc_q;
  bit              hold_sink;
  bit              sink_done;
  bpc_scoreboard   sb;

  barometric_pressure_compensation dut (.*);

  always #5 clk_i = ~clk_i;

  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic longint s16(logic [CalW-1:0] r, int pos);
    return longint'(signed'(r[pos+:16]));
  endfunction

  function automatic longint asr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint w32(longint v);
    return longint'(signed'(v[31:0]));
  endfunction

  function automatic longint sdiv(longint n, longint d);
    logic [63:0] un, ud, q;
    un = n < 0 ? -n : n;
    ud = d < 0 ? -d : d;
    q = un / ud;
    return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [71:0] compensate(logic [19:0] adc_p, logic [19:0] adc_t);
    longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    longint a, b, v1, v2, tf, x, y, dv, p;
    status_e st;
    logic [31:0] press;
    st = ST_OK;
    press = '0;
    if (!en_q) return {6'd0, 32'd0, 32'd0, ST_DISABLED};
    t1 = longint'(tcal_q[15:0]);
    t2 = s16(tcal_q, 16);
    t3 = s16(tcal_q, 32);
    p1 = longint'(pa_q[15:0]);
    p2 = s16(pa_q, 16);
    p3 = s16(pa_q, 32);
    p4 = s16(pb_q, 0);
    p5 = s16(pb_q, 16);
    p6 = s16(pb_q, 32);
    p7 = s16(pc_q, 0);
    p8 = s16(pc_q, 16);
    p9 = s16(pc_q, 32);
    a = longint'(adc_t >> 3) - (t1 << 1);
    v1 = asr(w32(a * t2), 11);
    b = longint'(adc_t >> 4) - t1;
    v2 = asr(w32(b * b), 12);
    v2 = asr(w32(v2 * t3), 14);
    tf = w32(v1 + v2);
    x = tf - 128000;
    y = x * x * p6;
    y = y + ((x * p5) << 17);
    y = y + (p4 << 35);
    dv = asr(x * x * p3, 8) + ((x * p2) << 12);
    dv = asr(((64'sd1 <<< 47) + dv) * p1, 33);
    if (dv == 0) begin
      st = ST_INVALID;
    end else begin
      p = 1048576 - longint'(adc_p);
      p = sdiv(((p << 31) - y) * 3125, dv);
      v1 = asr(p9 * asr(p, 13) * asr(p, 13), 25);
      v2 = asr(p8 * p, 19);
      p = asr(p + v1 + v2, 8) + (p7 << 4);
      if (p <= 0) st = ST_INVALID;
      else if (p > 64'sh0FFFF_FFFF) press = '1;
      else press = p[31:0];
    end
    return {6'd0, tf[31:0], st == ST_OK ? press : 32'd0, st};
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [CalW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    case (idx)
      REG_ENABLED:  en_q = val[0];
      REG_TEMP_CAL: tcal_q = val;
      REG_PRESS_A:  pa_q = val;
      REG_PRESS_B:  pb_q = val;
      default:      pc_q = val;
    endcase
  endtask

  // Handshake signals only change at the rising edge, so the falling edge
  // shows what the next rising edge will accept.
  task automatic send_sample(logic [19:0] rp, logic [19:0] rt);
    s_axis_tvalid <= 1;
    s_axis_tdata <= {rt, rp};
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    sb.note_sample(compensate(rp, rt));
  endtask

  task automatic idle_gap();
    if ($urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  task automatic load_cal(logic [CalW-1:0] t, a, b, c);
    write_reg(REG_TEMP_CAL, t);
    write_reg(REG_PRESS_A, a);
    write_reg(REG_PRESS_B, b);
    write_reg(REG_PRESS_C, c);
  endtask

  function automatic logic [CalW-1:0] rnd48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Typical calibration words with random jitter on each field.
  function automatic logic [CalW-1:0] jit(logic [CalW-1:0] base);
    logic [CalW-1:0] r;
    for (int i = 0; i < 3; i++) r[i*16+:16] = base[i*16+:16] + 16'($urandom_range(0, 63)) - 16'd32;
    return r;
  endfunction

  task automatic random_burst(int n, bit realistic);
    int i;
    i = 0;
    while (i < n) begin
      repeat ($urandom_range(1, 12)) begin
        if (i < n) begin
          if (realistic)
            send_sample(20'($urandom_range(200000, 600000)), 20'($urandom_range(400000, 600000)));
          else
            send_sample(20'($urandom), 20'($urandom));
          i++;
        end
      end
      idle_gap();
    end
  endtask

  always @(negedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  initial begin : sink
    int c;
    c = 0;
    forever begin
      @(posedge clk_i);
      if (hold_sink) m_axis_tready <= 0;
      else if (c < 40) m_axis_tready <= 1;
      else m_axis_tready <= ($urandom_range(0, 3) != 0);
      c = (c + 1) % 100;
    end
  end

  initial begin : main
    logic [CalW-1:0] tc, pa, pb, pc;
    sb = new();
    hold_sink = 0;
    en_q = 0; tcal_q = '0; pa_q = '0; pb_q = '0; pc_q = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    tc = {16'hFC18, 16'h6A00, 16'h6E00};
    pa = {16'h0BB8, 16'hD600, 16'h8E00};
    pb = {16'h0070, 16'hFFF9, 16'h2B00};
    pc = {16'h1770, 16'hC400, 16'h00C4};
    // disabled after reset
    send_sample(20'h00000, 20'hFFFFF);
    send_sample(20'hFFFFF, 20'h00000);
    drain();
    write_reg(REG_ENABLED, 48'h1);
    // all-zero calibration: zero divisor
    send_sample(20'h5A5A5, 20'hA5A5A);
    drain();
    load_cal(tc, pa, pb, pc);
    send_sample(20'd415148, 20'd519888);
    send_sample(20'h00000, 20'h00000);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'h00000, 20'hFFFFF);
    send_sample(20'hFFFFF, 20'h00000);
    send_sample(20'h55555, 20'hAAAAA);
    send_sample(20'hAAAAA, 20'h55555);
    drain();
    // extreme calibration words: wrapping, saturation, nonpositive pressure
    load_cal('1, '1, '1, '1);
    send_sample(20'h12345, 20'hFFFFF);
    send_sample(20'h00000, 20'h00000);
    drain();
    load_cal({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h8000, 16'hFFFF},
             {16'h8000, 16'h8000, 16'h8000}, {16'h8000, 16'h8000, 16'h8000});
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'h00001, 20'h00000);
    drain();
    load_cal({16'h7FFF, 16'h7FFF, 16'h0000}, {16'h7FFF, 16'h7FFF, 16'h0001},
             {16'h7FFF, 16'h7FFF, 16'h7FFF}, {16'h7FFF, 16'h7FFF, 16'h7FFF});
    send_sample(20'h00000, 20'h80000);
    send_sample(20'hFFFFF, 20'h7FFFF);
    drain();
    // extreme P7: largest positive with the lowest raw pressure, most negative with the highest
    load_cal(tc, pa, pb, {16'h0000, 16'h0000, 16'h7FFF});
    send_sample(20'h00000, 20'd519888);
    drain();
    load_cal(tc, pa, pb, {16'h0000, 16'h0000, 16'h8000});
    send_sample(20'hFFFFF, 20'd519888);
    drain();
    // long receiver hold-off while the sender keeps offering
    load_cal(tc, pa, pb, pc);
    hold_sink = 1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_sink = 0;
      end
      random_burst(150, 1);
    join
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      load_cal(jit(tc), jit(pa), jit(pb), jit(pc));
      random_burst(80, 1);
      random_burst(20, 0);
      drain();
    end
    load_cal(rnd48(), rnd48(), rnd48(), rnd48());
    random_burst(40, 0);
    drain();
    write_reg(REG_ENABLED, 48'h0);
    random_burst(10, 0);
    drain();
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
